@@ sv/ptc_pkg.sv @@
// ============================================================================
// ptc_pkg
// Shared types and constants for the pressure and temperature compensation
// pipeline and its pipelined divider.
// ============================================================================
package ptc_pkg;

    // Number of one-bit stages in the pipelined divider.
    localparam int DIV_STAGES = 32;

    // Output clamp limits for pressure in pascal.
    localparam logic [16:0] P_MIN = 17'd30000;
    localparam logic [16:0] P_MAX = 17'd110000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TEMP       = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_NINE = 2'd3
    } t_cfg_index;

    // Input word: one pair of raw readings.
    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } t_in_word;

    // Output word: compensated results.
    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic signed [23:0] fine_temp;
        logic [16:0]        pressure_pa;
    } t_out_word;

    // Temperature results that ride along the pressure path.
    typedef struct packed {
        logic signed [15:0] temp;
        logic signed [23:0] fine;
    } t_tf;

    // Side information carried through the divider.
    typedef struct packed {
        t_tf  tf;
        logic dbl;   // quotient must be doubled afterwards
        logic zero;  // divisor was zero
    } t_div_side;

endpackage

@@ sv/ptc_div.sv @@
// ============================================================================
// ptc_div
// Fully pipelined 32-bit unsigned restoring divider, one quotient bit per
// stage, with a valid bit and side information carried alongside.
// ============================================================================
module ptc_div import ptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    input  t_div_side   i_side,
    output logic        o_valid,
    output logic [31:0] o_quot,
    output t_div_side   o_side
);

    logic        r_vld  [DIV_STAGES];
    logic [31:0] r_rem  [DIV_STAGES];
    logic [31:0] r_num  [DIV_STAGES];
    logic [31:0] r_den  [DIV_STAGES];
    t_div_side   r_side [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic        w_vld_in;
        logic [31:0] w_rem_in;
        logic [31:0] w_num_in;
        logic [31:0] w_den_in;
        t_div_side   w_side_in;
        logic [32:0] w_trial;
        logic [32:0] w_diff;
        logic        w_ge;
        logic [31:0] n_rem;
        logic [31:0] n_num;

        // Stage inputs come from the port for the first stage.
        if (g == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_rem_in  = '0;
            assign w_num_in  = i_num;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_num_in  = r_num[g-1];
            assign w_den_in  = r_den[g-1];
            assign w_side_in = r_side[g-1];
        end

        // One trial subtraction per stage.
        always_comb begin
            w_trial = {w_rem_in, w_num_in[31]};
            w_diff  = w_trial - {1'b0, w_den_in};
            w_ge    = !w_diff[32];
            n_rem   = w_ge ? w_diff[31:0] : w_trial[31:0];
            n_num   = {w_num_in[30:0], w_ge};
        end

        // Valid bit of the stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld_in;
            end
        end

        // Data of the stage.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_num[g]  <= n_num;
                r_den[g]  <= w_den_in;
                r_side[g] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_num[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

@@ sv/pressure_temperature_compensation.sv @@
// ============================================================================
// pressure_temperature_compensation
// Integer compensation of raw temperature and pressure readings.
// ============================================================================
// The block takes one word of raw readings per clock while the output is not
// stalled and returns one word of compensated temperature, fine temperature
// and pressure for each, in order. It has eleven arithmetic stages, a 32-stage
// divider that retires one quotient bit per stage, three correction stages and
// the output register. A stall on the output holds the whole pipeline in
// place, so o_in_ready follows the output register. Coefficients must be
// written through the configuration port while no word is in flight; the block
// does not enforce this. A write always completes in the cycle it is offered.
module pressure_temperature_compensation import ptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Signed division by two to the k, truncating toward zero.
    function automatic logic signed [31:0] f_sdiv(input logic signed [31:0] x, input int k);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (x + bias) >>> k;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [47:0] r_tc;
    logic [63:0] r_pcl;
    logic [63:0] r_pch;
    logic [15:0] r_p9;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc  <= '0;
            r_pcl <= '0;
            r_pch <= '0;
            r_p9  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TEMP:       r_tc  <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_pcl <= i_cfg_data;
                CFG_PRESS_HIGH: r_pch <= i_cfg_data;
                CFG_PRESS_NINE: r_p9  <= i_cfg_data[15:0];
                default:        r_tc  <= r_tc;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = r_tc[15:0];
    assign t2 = $signed(r_tc[31:16]);
    assign t3 = $signed(r_tc[47:32]);
    assign p1 = r_pcl[15:0];
    assign p2 = $signed(r_pcl[31:16]);
    assign p3 = $signed(r_pcl[47:32]);
    assign p4 = $signed(r_pcl[63:48]);
    assign p5 = $signed(r_pch[15:0]);
    assign p6 = $signed(r_pch[31:16]);
    assign p7 = $signed(r_pch[47:32]);
    assign p8 = $signed(r_pch[63:48]);
    assign p9 = $signed(r_p9);

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves when the output can move.
    // ------------------------------------------------------------------
    logic w_en;
    logic r_out_valid;

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Stage 1: first temperature products.
    // ------------------------------------------------------------------
    logic signed [17:0] w_a_base;
    logic signed [33:0] w_a_prod;
    logic signed [16:0] w_d;
    logic               r1_vld;
    logic signed [33:0] r1_aprod;
    logic signed [16:0] r1_d;
    logic [19:0]        r1_press;

    always_comb begin
        w_a_base = $signed({1'b0, i_in_word.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
        w_a_prod = w_a_base * t2;
        w_d      = $signed({1'b0, i_in_word.raw_temp[19:4]}) - $signed({1'b0, t1});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_aprod <= w_a_prod;
            r1_d     <= w_d;
            r1_press <= i_in_word.raw_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: square of the offset.
    // ------------------------------------------------------------------
    logic               r2_vld;
    logic signed [33:0] r2_dd;
    logic signed [22:0] r2_a;
    logic [19:0]        r2_press;
    logic signed [33:0] w_a_sh;

    assign w_a_sh = r1_aprod >>> 11;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dd    <= r1_d * r1_d;
            r2_a     <= w_a_sh[22:0];
            r2_press <= r1_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: second-order temperature term.
    // ------------------------------------------------------------------
    logic               r3_vld;
    logic signed [37:0] r3_bprod;
    logic signed [22:0] r3_a;
    logic [19:0]        r3_press;
    logic signed [33:0] w_dd_sh;
    logic signed [21:0] w_dd12;

    always_comb begin
        w_dd_sh = r2_dd >>> 12;
        w_dd12  = w_dd_sh[21:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_bprod <= w_dd12 * t3;
            r3_a     <= r2_a;
            r3_press <= r2_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: fine temperature, saturated to 24 bits.
    // ------------------------------------------------------------------
    logic               r4_vld;
    logic signed [23:0] r4_fine;
    logic [19:0]        r4_press;
    logic signed [37:0] w_b_sh;
    logic signed [24:0] w_fsum;
    logic signed [23:0] w_fine;

    always_comb begin
        w_b_sh = r3_bprod >>> 14;
        w_fsum = r3_a + $signed(w_b_sh[23:0]);
        if (w_fsum > 25'sd8388607) begin
            w_fine = 24'sd8388607;
        end else if (w_fsum < -25'sd8388608) begin
            w_fine = -24'sd8388608;
        end else begin
            w_fine = w_fsum[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_fine  <= w_fine;
            r4_press <= r3_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: temperature in 0.01 degC and the first pressure offset.
    // ------------------------------------------------------------------
    logic               r5_vld;
    t_tf                r5_tf;
    logic signed [23:0] r5_v1;
    logic signed [21:0] r5_q;
    logic [19:0]        r5_press;
    logic signed [26:0] w_f5;
    logic signed [26:0] w_t_sh;
    logic signed [15:0] w_temp;
    logic signed [23:0] w_fh;
    logic signed [23:0] w_v1;
    logic signed [23:0] w_vb;
    logic signed [23:0] w_q24;

    always_comb begin
        w_f5   = r4_fine * 27'sd5 + 27'sd128;
        w_t_sh = w_f5 >>> 8;
        if (w_t_sh > 27'sd32767) begin
            w_temp = 16'sd32767;
        end else if (w_t_sh < -27'sd32768) begin
            w_temp = -16'sd32768;
        end else begin
            w_temp = w_t_sh[15:0];
        end
        w_fh  = r4_fine + $signed({23'd0, r4_fine[23]});
        w_v1  = (w_fh >>> 1) - 24'sd64000;
        w_vb  = w_v1 + $signed({22'd0, w_v1[23], w_v1[23]});
        w_q24 = w_vb >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_tf.temp <= w_temp;
            r5_tf.fine <= r4_fine;
            r5_v1      <= w_v1;
            r5_q       <= w_q24[21:0];
            r5_press   <= r4_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: square and linear products of the offset.
    // ------------------------------------------------------------------
    logic               r6_vld;
    t_tf                r6_tf;
    logic signed [31:0] r6_sq, r6_m5, r6_m2;
    logic [19:0]        r6_press;
    logic signed [43:0] w_sq_full;
    logic signed [39:0] w_m5_full, w_m2_full;

    always_comb begin
        w_sq_full = r5_q * r5_q;
        w_m5_full = r5_v1 * p5;
        w_m2_full = r5_v1 * p2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_tf    <= r5_tf;
            r6_sq    <= w_sq_full[31:0];
            r6_m5    <= w_m5_full[31:0];
            r6_m2    <= w_m2_full[31:0];
            r6_press <= r5_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: products of the scaled square.
    // ------------------------------------------------------------------
    logic               r7_vld;
    t_tf                r7_tf;
    logic signed [31:0] r7_m6, r7_m3, r7_m5, r7_m2;
    logic [19:0]        r7_press;
    logic signed [47:0] w_m6_full, w_m3_full;

    always_comb begin
        w_m6_full = f_sdiv(r6_sq, 11) * p6;
        w_m3_full = f_sdiv(r6_sq, 13) * p3;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_tf    <= r6_tf;
            r7_m6    <= w_m6_full[31:0];
            r7_m3    <= w_m3_full[31:0];
            r7_m5    <= r6_m5;
            r7_m2    <= r6_m2;
            r7_press <= r6_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: partial sums of both pressure terms.
    // ------------------------------------------------------------------
    logic               r8_vld;
    t_tf                r8_tf;
    logic signed [31:0] r8_v2a, r8_s;
    logic [19:0]        r8_press;
    logic signed [31:0] w_v34;

    assign w_v34 = f_sdiv(r7_m3, 3) + f_sdiv(r7_m2, 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_tf    <= r7_tf;
            r8_v2a   <= r7_m6 + (r7_m5 <<< 1);
            r8_s     <= f_sdiv(w_v34, 18);
            r8_press <= r7_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: offset term and the divisor base.
    // ------------------------------------------------------------------
    logic               r9_vld;
    t_tf                r9_tf;
    logic signed [31:0] r9_v2, r9_c;
    logic [19:0]        r9_press;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_tf    <= r8_tf;
            r9_v2    <= f_sdiv(r8_v2a, 2) + (32'(p4) <<< 16);
            r9_c     <= 32'sd32768 + r8_s;
            r9_press <= r8_press;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: divisor product and dividend base.
    // ------------------------------------------------------------------
    logic               r10_vld;
    t_tf                r10_tf;
    logic signed [31:0] r10_m1;
    logic [31:0]        r10_u0;
    logic signed [48:0] w_m1_full;
    logic [31:0]        w_v2d;

    always_comb begin
        w_m1_full = r9_c * $signed({1'b0, p1});
        w_v2d     = f_sdiv(r9_v2, 12);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_tf <= r9_tf;
            r10_m1 <= w_m1_full[31:0];
            r10_u0 <= (32'd1048576 - {12'd0, r9_press}) - w_v2d;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: divisor and dividend ready for the divider.
    // ------------------------------------------------------------------
    logic        r11_vld;
    t_tf         r11_tf;
    logic [31:0] r11_den;
    logic [31:0] r11_u;
    logic [43:0] w_u_full;
    logic [31:0] w_num;
    t_div_side   w_div_side;

    assign w_u_full = r10_u0 * 12'd3125;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_tf  <= r10_tf;
            r11_den <= f_sdiv(r10_m1, 15);
            r11_u   <= w_u_full[31:0];
        end
    end

    // Large dividends are divided as they are and the quotient doubled.
    always_comb begin
        w_num           = r11_u[31] ? r11_u : {r11_u[30:0], 1'b0};
        w_div_side.tf   = r11_tf;
        w_div_side.dbl  = r11_u[31];
        w_div_side.zero = (r11_den == 32'd0);
    end

    // ------------------------------------------------------------------
    // Pipelined divider.
    // ------------------------------------------------------------------
    logic        w_dq_vld;
    logic [31:0] w_quot;
    t_div_side   w_dq_side;

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r11_vld),
        .i_num   (w_num),
        .i_den   (r11_den),
        .i_side  (w_div_side),
        .o_valid (w_dq_vld),
        .o_quot  (w_quot),
        .o_side  (w_dq_side)
    );

    // ------------------------------------------------------------------
    // Correction stage 1: quotient products.
    // ------------------------------------------------------------------
    logic        rp1_vld;
    t_tf         rp1_tf;
    logic        rp1_zero;
    logic [31:0] rp1_r;
    logic [31:0] rp1_m9a;
    logic signed [31:0] rp1_m8;
    logic [31:0] w_r;
    logic [57:0] w_m9a_full;
    logic signed [46:0] w_m8_full;

    always_comb begin
        w_r        = w_dq_side.dbl ? {w_quot[30:0], 1'b0} : w_quot;
        w_m9a_full = w_r[31:3] * w_r[31:3];
        w_m8_full  = $signed({1'b0, w_r[31:2]}) * p8;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rp1_tf   <= w_dq_side.tf;
            rp1_zero <= w_dq_side.zero;
            rp1_r    <= w_r;
            rp1_m9a  <= w_m9a_full[31:0];
            rp1_m8   <= w_m8_full[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Correction stage 2: second-order pressure correction.
    // ------------------------------------------------------------------
    logic        rp2_vld;
    t_tf         rp2_tf;
    logic        rp2_zero;
    logic [31:0] rp2_r;
    logic signed [31:0] rp2_m9, rp2_v2b;
    logic signed [35:0] w_m9_full;

    assign w_m9_full = $signed({1'b0, rp1_m9a[31:13]}) * p9;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rp2_tf   <= rp1_tf;
            rp2_zero <= rp1_zero;
            rp2_r    <= rp1_r;
            rp2_m9   <= w_m9_full[31:0];
            rp2_v2b  <= f_sdiv(rp1_m8, 13);
        end
    end

    // ------------------------------------------------------------------
    // Correction stage 3: correction sum.
    // ------------------------------------------------------------------
    logic        rp3_vld;
    t_tf         rp3_tf;
    logic        rp3_zero;
    logic [31:0] rp3_r;
    logic signed [31:0] rp3_sum;
    logic signed [31:0] w_csum;

    assign w_csum = f_sdiv(rp2_m9, 12) + rp2_v2b + 32'(p7);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rp3_tf   <= rp2_tf;
            rp3_zero <= rp2_zero;
            rp3_r    <= rp2_r;
            rp3_sum  <= f_sdiv(w_csum, 4);
        end
    end

    // ------------------------------------------------------------------
    // Output register: final pressure with clamp.
    // ------------------------------------------------------------------
    logic [31:0] w_p;
    logic [16:0] w_press;
    t_out_word   r_out_word;

    always_comb begin
        w_p = rp3_r + rp3_sum;
        if (rp3_zero || w_p < {15'd0, P_MIN}) begin
            w_press = P_MIN;
        end else if (w_p > {15'd0, P_MAX}) begin
            w_press = P_MAX;
        end else begin
            w_press = w_p[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_word.temperature_centi <= rp3_tf.temp;
            r_out_word.fine_temp         <= rp3_tf.fine;
            r_out_word.pressure_pa       <= w_press;
        end
    end

    assign o_out_word = r_out_word;

    // ------------------------------------------------------------------
    // Valid bits of all stages outside the divider.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r5_vld      <= 1'b0;
            r6_vld      <= 1'b0;
            r7_vld      <= 1'b0;
            r8_vld      <= 1'b0;
            r9_vld      <= 1'b0;
            r10_vld     <= 1'b0;
            r11_vld     <= 1'b0;
            rp1_vld     <= 1'b0;
            rp2_vld     <= 1'b0;
            rp3_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_vld      <= i_in_valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r5_vld      <= r4_vld;
            r6_vld      <= r5_vld;
            r7_vld      <= r6_vld;
            r8_vld      <= r7_vld;
            r9_vld      <= r8_vld;
            r10_vld     <= r9_vld;
            r11_vld     <= r10_vld;
            rp1_vld     <= w_dq_vld;
            rp2_vld     <= rp1_vld;
            rp3_vld     <= rp2_vld;
            r_out_valid <= rp3_vld;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_press_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.pressure_pa >= P_MIN && o_out_word.pressure_pa <= P_MAX))
        else $error("pressure outside clamp range");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r1_vld)
        else $error("accepted word did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r11_vld) && $stable(rp3_vld) && $stable(w_dq_vld)))
        else $error("pipeline moved during a stall");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the pressure and temperature compensation pipeline.
// Directed and random raw readings run under several coefficient settings, and
// every output word is checked field by field against an integer predictor.
// ============================================================================

// Holds the coefficients and the queue of predicted output words.
class ptc_scoreboard;
    logic [47:0] temp_coeffs;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_nine;
    ptc_pkg::t_out_word predicted_q[$];
    int errors;
    int checked;

    function new();
        temp_coeffs = '0;
        press_low = '0;
        press_high = '0;
        press_nine = '0;
        errors = 0;
        checked = 0;
    endfunction

    // Mirror one coefficient register write.
    function void write_coeff(ptc_pkg::t_cfg_index idx, logic [63:0] data);
        case (idx)
            ptc_pkg::CFG_TEMP:       temp_coeffs = data[47:0];
            ptc_pkg::CFG_PRESS_LOW:  press_low = data;
            ptc_pkg::CFG_PRESS_HIGH: press_high = data;
            ptc_pkg::CFG_PRESS_NINE: press_nine = data[15:0];
            default: ;
        endcase
    endfunction

    // Wrapping 32-bit product.
    function logic signed [31:0] wmul(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [31:0] r;
        r = a * b;
        return r;
    endfunction

    // Arithmetic shift right that rounds toward minus infinity.
    function longint ashr(longint v, int n);
        return v >>> n;
    endfunction

    // Compute the compensated word for one pair of raw readings.
    function ptc_pkg::t_out_word compensate(ptc_pkg::t_in_word w);
        ptc_pkg::t_out_word o;
        longint adc_t, t1, t2, t3, a, b, d, fine, temp;
        logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [31:0] v1, v2, v3, v4, q, sq;
        logic [31:0] adc_p, dv, u, r, p;
        adc_t = longint'(w.raw_temp);
        adc_p = 32'(w.raw_press);
        t1 = longint'(temp_coeffs[15:0]);
        t2 = longint'($signed(temp_coeffs[31:16]));
        t3 = longint'($signed(temp_coeffs[47:32]));
        p1 = 32'(press_low[15:0]);
        p2 = 32'($signed(press_low[31:16]));
        p3 = 32'($signed(press_low[47:32]));
        p4 = 32'($signed(press_low[63:48]));
        p5 = 32'($signed(press_high[15:0]));
        p6 = 32'($signed(press_high[31:16]));
        p7 = 32'($signed(press_high[47:32]));
        p8 = 32'($signed(press_high[63:48]));
        p9 = 32'($signed(press_nine));

        // Temperature in fixed point with saturation.
        a = ashr(((adc_t >>> 3) - t1 * 2) * t2, 11);
        d = (adc_t >>> 4) - t1;
        b = ashr(ashr(d * d, 12) * t3, 14);
        fine = a + b;
        if (fine < -8388608) fine = -8388608;
        if (fine > 8388607) fine = 8388607;
        temp = ashr(fine * 5 + 128, 8);
        if (temp < -32768) temp = -32768;
        if (temp > 32767) temp = 32767;

        // Pressure: 32-bit wrapping steps, divisions truncate toward zero.
        v1 = 32'(fine) / 2 - 64000;
        q = v1 / 4;
        sq = wmul(q, q);
        v2 = wmul(sq / 2048, p6);
        v2 = v2 + wmul(wmul(v1, p5), 2);
        v2 = v2 / 4 + wmul(p4, 65536);
        v3 = wmul(p3, sq / 8192) / 8;
        v4 = wmul(p2, v1) / 2;
        v1 = (v3 + v4) / 262144;
        v1 = wmul(32768 + v1, p1) / 32768;
        if (v1 != 0) begin
            dv = v1;
            u = (32'd1048576 - adc_p) - 32'(v2 / 4096);
            u = u * 32'd3125;
            if (u < 32'h8000_0000) r = (u << 1) / dv;
            else r = (u / dv) * 32'd2;
            v1 = wmul(p9, $signed(((r >> 3) * (r >> 3)) >> 13)) / 4096;
            v2 = wmul($signed(r >> 2), p8) / 8192;
            p = $signed(r) + (v1 + v2 + p7) / 16;
            if (p < 32'd30000) p = 32'd30000;
            else if (p > 32'd110000) p = 32'd110000;
        end else begin
            p = 32'd30000;
        end
        o.temperature_centi = 16'(temp);
        o.fine_temp = 24'(fine);
        o.pressure_pa = p[16:0];
        return o;
    endfunction

    // Note an accepted input word.
    function void note_input(ptc_pkg::t_in_word w);
        predicted_q.push_back(compensate(w));
    endfunction

    // Check one output word against the oldest prediction.
    function void check_output(ptc_pkg::t_out_word got);
        ptc_pkg::t_out_word exp_w;
        if (predicted_q.size() == 0) begin
            $display("%0t: unexpected output word %h", $time, got);
            errors++;
            return;
        end
        exp_w = predicted_q.pop_front();
        checked++;
        if (got.temperature_centi !== exp_w.temperature_centi) begin
            $display("%0t: temperature_centi expected %0d actual %0d", $time,
                     exp_w.temperature_centi, got.temperature_centi);
            errors++;
        end
        if (got.fine_temp !== exp_w.fine_temp) begin
            $display("%0t: fine_temp expected %0d actual %0d", $time,
                     exp_w.fine_temp, got.fine_temp);
            errors++;
        end
        if (got.pressure_pa !== exp_w.pressure_pa) begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time,
                     exp_w.pressure_pa, got.pressure_pa);
            errors++;
        end
    endfunction
endclass

module tb;
    import ptc_pkg::*;

    localparam int LATENCY = 47;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    ptc_scoreboard sb;
    int  idle_cycles;
    bit  hold_output;
    bit  sink_enable;
    int  words_sent;
    int  settings_run;

    pressure_temperature_compensation i_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Short gaps mostly, a long one now and then, and stretches with none.
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side: random back-pressure, plus a long forced hold-off.
    initial begin
        int g;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_output) begin
                i_out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_output = 1'b0;
            end
            g = sink_enable ? gap_len() : 0;
            if (g == 0) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // Monitor: inputs and outputs accepted at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_input(i_in_word);
            if (o_out_valid && i_out_ready) sb.check_output(o_out_word);
            // The watchdog counts edges at which no word moves on any channel.
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Send one input word, with an optional gap in front.
    task automatic send_word(logic [19:0] rt, logic [19:0] rp, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= '{raw_temp: rt, raw_press: rp};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Drop valid and wait for every prediction to retire, then drain.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.predicted_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Offer one register write and wait for it to be taken; the caller drops valid.
    task automatic write_reg(t_cfg_index idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_coeff(idx, data);
    endtask

    task automatic set_coeffs(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                              logic [15:0] p9);
        write_reg(CFG_TEMP, {16'h0, tc});
        write_reg(CFG_PRESS_LOW, pl);
        write_reg(CFG_PRESS_HIGH, ph);
        write_reg(CFG_PRESS_NINE, {48'h0, p9});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_run++;
    endtask

    // Random raw pair: mostly near typical readings, sometimes any value.
    task automatic send_random(int n);
        logic [19:0] rt, rp;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                rt = 20'($urandom_range(400000, 600000));
                rp = 20'($urandom_range(250000, 450000));
            end else begin
                rt = 20'($urandom);
                rp = 20'($urandom);
            end
            send_word(rt, rp, 1'b1);
        end
    endtask

    // Typical calibration set with small random perturbations.
    localparam logic [47:0] TYP_T = {16'd50, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PL = {16'd2855, 16'hF1E2, 16'hD5AE, 16'd36477};
    localparam logic [63:0] TYP_PH = {16'hEE61, 16'd3920, 16'hFFF9, 16'h008C};
    localparam logic [15:0] TYP_P9 = 16'd4283;

    initial begin
        sb = new();
        idle_cycles = 0;
        hold_output = 1'b0;
        sink_enable = 1'b0;
        words_sent = 0;
        settings_run = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TEMP;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients: divisor is zero, pressure sits at the floor.
        send_word(20'h0, 20'h0, 1'b0);
        send_word(20'hFFFFF, 20'hFFFFF, 1'b0);
        drain();

        // Typical calibration with field extremes, back-to-back.
        set_coeffs(TYP_T, TYP_PL, TYP_PH, TYP_P9);
        send_word(20'h0, 20'h0, 1'b0);
        send_word(20'hFFFFF, 20'hFFFFF, 1'b0);
        send_word(20'h0, 20'hFFFFF, 1'b0);
        send_word(20'hFFFFF, 20'h0, 1'b0);
        send_word(20'h5555A, 20'hAAAA5, 1'b0);
        send_word(20'hAAAA5, 20'h5555A, 1'b0);
        send_word(20'd519888, 20'd415148, 1'b0);
        send_word(20'd519888, 20'd100, 1'b0);
        drain();

        // Coefficient extremes: set the temperature coefficients to their limits and
        // drive the pressure path into wrap and clamp at both ends.
        set_coeffs({16'h7FFF, 16'h7FFF, 16'hFFFF}, '1, '1, 16'h7FFF);
        send_word(20'hFFFFF, 20'h0, 1'b0);
        send_word(20'h0, 20'hFFFFF, 1'b0);
        drain();
        set_coeffs({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000,
                   16'h8000, 16'hFFFF}, {4{16'h8000}}, 16'h8000);
        send_word(20'hFFFFF, 20'hFFFFF, 1'b0);
        send_word(20'h0, 20'h0, 1'b0);
        drain();
        set_coeffs({16'h0, 16'h0, 16'hFFFF}, 64'h0000_0000_0000_0001, '0, '0);
        send_word(20'h12345, 20'h0, 1'b0);
        send_word(20'hFFFFF, 20'hFFFFF, 1'b0);
        drain();

        // Random phases, each with coefficients set anew: typical, perturbed or random.
        sink_enable = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0 || ph == 4)
                set_coeffs(TYP_T, TYP_PL, TYP_PH, TYP_P9);
            else if (ph % 2 == 1)
                set_coeffs(TYP_T ^ 48'($urandom_range(0, 255)),
                           TYP_PL ^ 64'($urandom_range(0, 1023)),
                           TYP_PH ^ 64'($urandom_range(0, 1023)),
                           TYP_P9 ^ 16'($urandom_range(0, 255)));
            else
                set_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom},
                           {$urandom, $urandom}, 16'($urandom));
            // Hold the output long enough to fill the pipeline.
            if (ph == 2) hold_output = 1'b1;
            send_random(210);
            drain();
        end

        repeat (LATENCY) @(posedge i_clk);
        $display("Sent %0d words over %0d coefficient settings; %0d words checked.",
                 words_sent, settings_run, sb.checked);
        if (sb.errors == 0 && sb.predicted_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
